// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the alarm match unit.
// Each macro places one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== design/mam_pkg.sv =====
// Package for the alarm match unit: field widths, command codes and the
// structs passed between the top level and the alarm slots. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mam_pkg;

	localparam int CMD_W      = 2;
	localparam int INDEX_W    = 2;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int MASK_BITS  = 3;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;
	localparam int NUM_ALARMS_DEFAULT = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_TOGGLE = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                command;
		logic [INDEX_W-1:0]  alarm_index;
		logic [HOUR_W-1:0]   hour_value;
		logic [MINUTE_W-1:0] minute_value;
		logic                enable_value;
	} item_t;

	typedef struct packed {
		logic en_next;
		logic fire;
	} slot_stat_t;

endpackage

`default_nettype wire

// ===== design/mam_alarm_slot.sv =====
// One alarm entry: stored time, enable bit and fired latch, with its update rule.
// Depends on mam_pkg for the item struct, command codes and status struct.
`timescale 1ns / 1ps
`default_nettype none

module mam_alarm_slot
	import mam_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       commit,
	input  wire logic       sel,
	input  wire item_t      item,
	output slot_stat_t      status
);

	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic                en_q;
	logic                latched_q;

	logic is_tick;
	logic hour_eq;
	logic minute_eq;
	logic rearm;

	assign is_tick   = (item.command == CMD_TICK);
	assign hour_eq   = (item.hour_value == hour_q);
	assign minute_eq = (item.minute_value == minute_q);

	// Rearm needs both hour and minute to differ from the stored time.
	assign rearm = is_tick && en_q && !hour_eq && !minute_eq && latched_q;

	always_comb begin
		status.fire    = is_tick && en_q && hour_eq && minute_eq && !latched_q;
		status.en_next = en_q;
		if (!is_tick && sel) begin
			unique case (item.command)
				CMD_TOGGLE: status.en_next = !en_q;
				CMD_WRITE:  status.en_next = item.enable_value;
				default:    status.en_next = en_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q    <= '0;
			minute_q  <= '0;
			en_q      <= 1'b0;
			latched_q <= 1'b0;
		end else if (commit) begin
			en_q <= status.en_next;
			if (sel && (item.command == CMD_SET)) begin
				hour_q   <= item.hour_value;
				minute_q <= item.minute_value;
			end
			if (status.fire) begin
				latched_q <= 1'b1;
			end else if (rearm) begin
				latched_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/multi_alarm_match_unit.sv =====
// Top level of the alarm match unit: input stage, alarm slots and result register.
// Depends on mam_pkg, mam_alarm_slot and assert_macros.svh.
//
// Usage:
//   Commands and ticks enter on the s_ channel. s_tuser carries the command
//   (tick, set time, toggle enable, write enable); s_tdata carries the alarm
//   index, hour, minute and enable value. Every input transaction produces
//   exactly one result transaction on the m_ channel, in order.
//   Path: an accepted transaction is registered in the input stage, evaluated
//   against the alarm table, and its result is registered in the result
//   register, which drives m_tvalid.
//   Throughput: one transaction per cycle unless m_tready stalls the result
//   register. The table lookup is a set of parallel compares, one per alarm,
//   between the input stage and the result register; the table is updated at
//   the edge where the result is loaded, so the next item already sees the new state.
//   Stalls: while m_tready is low with a result waiting, the input stage
//   still takes one more transaction; after that s_tready drops until the
//   result register drains. Nothing is lost or repeated.
//   Reset: arst_n clears all alarm times, enable bits and latches to zero and
//   empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module multi_alarm_match_unit
	import mam_pkg::*;
#(
	parameter int NUM_ALARMS = NUM_ALARMS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// Fields from bit 0: alarm_index[1:0], hour_value[6:2], minute_value[12:7],
	// enable_value[13], zero fill[15:14].
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// Fields from bit 0: command[1:0].
	input  wire logic [CMD_W-1:0]      s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// Fields from bit 0: fire_mask[2:0], any_fire[3], enabled_mask[6:4], zero fill[7].
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	// Input stage holding one item.
	logic  valid_s1;
	item_t item_s1;

	// Result register.
	logic                 valid_s2;
	logic [MASK_BITS-1:0] fire_mask_s2;
	logic                 any_fire_s2;
	logic [MASK_BITS-1:0] enabled_mask_s2;

	logic                  advance;
	logic                  commit;
	logic                  s_accept;
	logic [NUM_ALARMS-1:0] sel_oh;
	logic [NUM_ALARMS-1:0] fire_all;
	logic [NUM_ALARMS-1:0] en_all;
	logic [MASK_BITS-1:0]  fire_mask_d;
	logic [MASK_BITS-1:0]  enabled_mask_d;
	slot_stat_t            slot_stat [NUM_ALARMS];
	logic                  unused_fill;

	// The result register can load when it is empty or being drained.
	assign advance  = !valid_s2 || m_tready;
	assign commit   = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// The zero-fill bits of s_tdata carry no information.
	assign unused_fill = ^s_tdata[IN_DATA_W-1:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.command      <= cmd_t'(s_tuser);
			item_s1.alarm_index  <= s_tdata[1:0];
			item_s1.hour_value   <= s_tdata[6:2];
			item_s1.minute_value <= s_tdata[12:7];
			item_s1.enable_value <= s_tdata[13];
		end
	end

	// One slot per alarm; an index at or above NUM_ALARMS selects none.
	for (genvar k = 0; k < NUM_ALARMS; k++) begin : g_slot
		assign sel_oh[k] = (int'(item_s1.alarm_index) == k);

		mam_alarm_slot u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.commit (commit),
			.sel    (sel_oh[k]),
			.item   (item_s1),
			.status (slot_stat[k])
		);

		assign fire_all[k] = slot_stat[k].fire;
		assign en_all[k]   = slot_stat[k].en_next;
	end

	// Only the first MASK_BITS alarms have a bit in the masks; all count for any_fire.
	for (genvar b = 0; b < MASK_BITS; b++) begin : g_mask
		if (b < NUM_ALARMS) begin : g_live
			assign fire_mask_d[b]    = fire_all[b];
			assign enabled_mask_d[b] = en_all[b];
		end else begin : g_none
			assign fire_mask_d[b]    = 1'b0;
			assign enabled_mask_d[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			fire_mask_s2    <= fire_mask_d;
			any_fire_s2     <= |fire_all;
			enabled_mask_s2 <= enabled_mask_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {unused_fill & 1'b0, enabled_mask_s2, any_fire_s2, fire_mask_s2};

	`include "assert_macros.svh"

	// A slot may only fire for a tick.
	`ASSERT_IMPL(a_fire_only_on_tick, clk, arst_n, valid_s1 && (|fire_all), item_s1.command == CMD_TICK)
	// A fire bit in the delivered result always comes with any_fire.
	`ASSERT_IMPL(a_mask_implies_any, clk, arst_n, m_tvalid && (|m_tdata[2:0]), m_tdata[3])
	// An item blocked in the input stage stays there unchanged.
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(item_s1))

endmodule

`default_nettype wire

// ===== bench/multi_alarm_match_unit_test.sv =====
// Self-checking bench for multi_alarm_match_unit: directed and random command and tick
// transactions, with an in-bench alarm table predictor. Depends on mam_pkg and the RTL.
`timescale 1ns / 1ps

module multi_alarm_match_unit_test;
	import mam_pkg::*;

	localparam int N_ALARMS      = NUM_ALARMS_DEFAULT;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int REPORT_LIMIT  = 10;

	// Traffic phases: who idles, by how many cycles in a hundred.
	localparam int PHASE_SENDER_LIGHT = 0;
	localparam int PHASE_SENDER_HEAVY = 1;
	localparam int PHASE_NO_IDLE      = 2;

	// Packed from the top bit down, so fire_mask lands in the lowest bits as on m_tdata.
	typedef struct packed {
		logic [MASK_BITS-1:0] enabled_mask;
		logic                 any_fire;
		logic [MASK_BITS-1:0] fire_mask;
	} alarm_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// Fields from bit 0: alarm_index, hour_value, minute_value, enable_value, zero fill.
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// Fields from bit 0: command.
	logic [CMD_W-1:0]      s_tuser = CMD_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// Fields from bit 0: fire_mask, any_fire, enabled_mask, zero fill.
	logic [OUT_DATA_W-1:0] m_tdata;

	multi_alarm_match_unit #(.NUM_ALARMS(N_ALARMS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predicted alarm table, cleared like the block at reset.
	logic [HOUR_W-1:0]   slot_hour   [N_ALARMS] = '{default: '0};
	logic [MINUTE_W-1:0] slot_minute [N_ALARMS] = '{default: '0};
	logic                slot_enable [N_ALARMS] = '{default: 1'b0};
	logic                slot_latch  [N_ALARMS] = '{default: 1'b0};

	item_t         pending_items [$];
	alarm_result_t expected_results [$];
	item_t         in_flight;
	int            total_items = 0;
	int            accepted_count = 0;
	int            mismatch_count = 0;
	int            quiet_cycles = 0;

	// Applies one transaction to the predicted table and returns the result it must give.
	// A latched alarm rearms only when hour and minute both differ from the tick time.
	function automatic alarm_result_t predict_alarm_result(item_t it);
		alarm_result_t r;
		r = '0;
		if (it.command == CMD_TICK) begin
			for (int k = 0; k < N_ALARMS; k++) begin
				if (!slot_enable[k])
					continue;
				if (it.hour_value == slot_hour[k] && it.minute_value == slot_minute[k]
						&& !slot_latch[k]) begin
					slot_latch[k] = 1'b1;
					r.any_fire = 1'b1;
					if (k < MASK_BITS)
						r.fire_mask[k] = 1'b1;
				end else if (it.hour_value != slot_hour[k] && it.minute_value != slot_minute[k]
						&& slot_latch[k]) begin
					slot_latch[k] = 1'b0;
				end
			end
		end else if (it.alarm_index < N_ALARMS) begin
			case (it.command)
				CMD_SET: begin
					slot_hour[it.alarm_index] = it.hour_value;
					slot_minute[it.alarm_index] = it.minute_value;
				end
				CMD_TOGGLE: slot_enable[it.alarm_index] = ~slot_enable[it.alarm_index];
				default: slot_enable[it.alarm_index] = it.enable_value;
			endcase
		end
		for (int k = 0; k < N_ALARMS && k < MASK_BITS; k++)
			r.enabled_mask[k] = slot_enable[k];
		return r;
	endfunction

	function automatic int traffic_phase();
		return (total_items == 0) ? PHASE_SENDER_LIGHT : accepted_count * 3 / total_items;
	endfunction

	function automatic int sender_idle_pct();
		case (traffic_phase())
			PHASE_SENDER_LIGHT: return 26;
			PHASE_SENDER_HEAVY: return 57;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (traffic_phase())
			PHASE_SENDER_LIGHT: return 57;
			PHASE_SENDER_HEAVY: return 26;
			default: return 0;
		endcase
	endfunction

	task automatic queue_item(cmd_t c, int idx, int h, int m, int en);
		item_t it;
		it.command = c;
		it.alarm_index = idx[INDEX_W-1:0];
		it.hour_value = h[HOUR_W-1:0];
		it.minute_value = m[MINUTE_W-1:0];
		it.enable_value = en[0];
		pending_items.push_back(it);
	endtask

	// One alarm life: set a time, then a write that enables it or a toggle, then ticks that hit
	// the alarm time, share only its hour or minute, or miss both, among more toggles and writes.
	task automatic queue_alarm_scenario();
		int k;
		int h;
		int m;
		k = ($urandom_range(9) == 0) ? 3 : $urandom_range(N_ALARMS - 1);
		h = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(23);
		m = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(59);
		queue_item(CMD_SET, k, h, m, $urandom_range(1));
		if ($urandom_range(1))
			queue_item(CMD_WRITE, k, $urandom_range(31), $urandom_range(63), 1);
		else
			queue_item(CMD_TOGGLE, k, $urandom_range(31), $urandom_range(63), $urandom_range(1));
		repeat ($urandom_range(2, 8)) begin
			case ($urandom_range(5))
				0, 1: queue_item(CMD_TICK, $urandom_range(3), h, m, $urandom_range(1));
				2: queue_item(CMD_TICK, $urandom_range(3), h, (m + $urandom_range(1, 63)) % 64,
						$urandom_range(1));
				3: queue_item(CMD_TICK, $urandom_range(3), (h + $urandom_range(1, 31)) % 32, m,
						$urandom_range(1));
				4: queue_item(CMD_TICK, $urandom_range(3), (h + $urandom_range(1, 31)) % 32,
						(m + $urandom_range(1, 63)) % 64, $urandom_range(1));
				default: begin
					if ($urandom_range(1))
						queue_item(CMD_TOGGLE, k, $urandom_range(31), $urandom_range(63),
							$urandom_range(1));
					else
						queue_item(CMD_WRITE, k, $urandom_range(31), $urandom_range(63),
							$urandom_range(1));
				end
			endcase
		end
	endtask

	task automatic report_mismatch(string field, int want_v, int got_v);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// Driver: holds a transaction until it is taken, then predicts its result and
	// either offers the next one or leaves s_tvalid low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_TICK;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_alarm_result(in_flight));
				accepted_count <= accepted_count + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					in_flight = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, in_flight.enable_value, in_flight.minute_value,
						in_flight.hour_value, in_flight.alarm_index};
					s_tuser <= in_flight.command;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result transaction against the oldest prediction and
	// stalls the result side at random.
	always @(posedge clk or negedge arst_n) begin : monitor
		alarm_result_t want;
		alarm_result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[2*MASK_BITS:0];
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", -1, m_tdata);
				end else begin
					want = expected_results.pop_front();
					if (got.fire_mask != want.fire_mask)
						report_mismatch("fire_mask", want.fire_mask, got.fire_mask);
					if (got.any_fire != want.any_fire)
						report_mismatch("any_fire", want.any_fire, got.any_fire);
					if (got.enabled_mask != want.enabled_mask)
						report_mismatch("enabled_mask", want.enabled_mask, got.enabled_mask);
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	// Watchdog: ends the run when neither side moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		// Directed: reset state, firing and latching, the rearm rule, extreme and
		// out-of-range time values, disabled alarms keeping their latch, and an
		// index past the last alarm being ignored.
		queue_item(CMD_TICK, 0, 0, 0, 0);
		queue_item(CMD_WRITE, 0, 0, 0, 1);
		queue_item(CMD_TICK, 0, 0, 0, 0);
		queue_item(CMD_TICK, 0, 0, 0, 0);
		queue_item(CMD_SET, 1, 31, 63, 0);
		queue_item(CMD_TOGGLE, 1, 0, 0, 0);
		queue_item(CMD_TICK, 3, 31, 63, 1);
		queue_item(CMD_SET, 2, 23, 59, 1);
		queue_item(CMD_WRITE, 2, 31, 63, 1);
		queue_item(CMD_TICK, 0, 23, 59, 0);
		queue_item(CMD_TICK, 0, 23, 0, 0);
		queue_item(CMD_TICK, 0, 0, 59, 0);
		queue_item(CMD_TICK, 0, 23, 59, 0);
		queue_item(CMD_WRITE, 2, 0, 0, 0);
		queue_item(CMD_TICK, 0, 5, 5, 0);
		queue_item(CMD_WRITE, 2, 0, 0, 1);
		queue_item(CMD_TICK, 0, 23, 59, 0);
		queue_item(CMD_SET, 3, 7, 7, 1);
		queue_item(CMD_TOGGLE, 3, 7, 7, 1);
		queue_item(CMD_WRITE, 3, 7, 7, 1);
		queue_item(CMD_SET, 0, 12, 30, 0);
		queue_item(CMD_SET, 1, 12, 30, 0);
		queue_item(CMD_SET, 2, 12, 30, 0);
		queue_item(CMD_TICK, 0, 12, 30, 0);
		queue_item(CMD_TOGGLE, 1, 0, 0, 0);

		// Random: mostly alarm scenarios, the rest unconstrained noise.
		while (pending_items.size() < RANDOM_ITEMS) begin
			if ($urandom_range(9) < 7)
				queue_alarm_scenario();
			else
				queue_item(cmd_t'($urandom_range(3)), $urandom_range(3), $urandom_range(31),
					$urandom_range(63), $urandom_range(1));
		end
		total_items = pending_items.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count != total_items)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
